FILE: hdl/dncts_pkg.sv
// Package for the day/night color temperature scheduler.
// Holds payload structs, register indexes, the force-mode enum and the sequencer state enum.
package dncts_pkg;

  localparam int unsigned SecondsPerDay = 86400;

  // A day is 675 * 128 seconds. The remainder by 675 uses a reciprocal that is
  // exact for every dividend below 2^26.
  localparam int unsigned DayFactor = 675;
  localparam logic [26:0] DayRecip = 27'd101806633;

  typedef enum logic [2:0] {
    CfgLowTemp   = 3'd0,
    CfgHighTemp  = 3'd1,
    CfgSunrise   = 3'd2,
    CfgSunset    = 3'd3,
    CfgDuration  = 3'd4,
    CfgDayOffset = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ForceOff  = 2'd0,
    ForceHigh = 2'd1,
    ForceLow  = 2'd2
  } force_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [15:0] temperature;
    logic [31:0] deadline;
    logic [1:0]  force_mode;
    logic        temp_changed;
  } out_item_t;

  // Divider request and reply between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [39:0] dividend;
    logic [39:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [39:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StDayAbs,
    StDayMul,
    StDayRem,
    StDaySel,
    StStops,
    StStepDiv,
    StStepWait,
    StMul,
    StRampDiv,
    StRampWait,
    StOut
  } state_e;

endpackage

FILE: hdl/dncts_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on dncts_pkg for the request and reply structs.
module dncts_div
  import dncts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned W = 40;

  logic [W-1:0] quo_q, quo_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] dvs_q, dvs_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [W:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("divider done without busy");

  property p_start_busy;
    @(posedge clk_i) disable iff (!rst_ni) req_i.start |=> busy_q;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("divider did not start");

  property p_cnt_zero_idle;
    @(posedge clk_i) disable iff (!rst_ni) !busy_q |-> !$past(req_i.start) || busy_q;
  endproperty
  a_cnt_zero_idle: assert property (p_cnt_zero_idle) else $error("divider lost a request");

endmodule

FILE: hdl/day_night_color_temp_scheduler_unit.sv
// Top level of the day/night color temperature scheduler.
// Depends on dncts_pkg and dncts_div (shared serial divider).
//
// The result of an item is registered after the states StDayAbs, StDayMul, StDayRem and
// StDaySel; a forced mode then goes straight to StOut, and otherwise StMul picks the
// segment, where before dawn, the day plateau and after dusk are final and a ramp waits
// on the divider. Recomputing the stops runs the divider for the step time when high is
// above low. The local day is found by a reciprocal multiplication; the step time and the
// ramp fraction run through one shared 40-bit divider at one quotient bit per cycle. One
// item is in work at a time, and the block is ready again as the result is registered.
// The result waits in an output register, so the next item can be worked on while it is
// held; only its own result then waits for that register to free.
module day_night_color_temp_scheduler_unit
  import dncts_pkg::*;
#(
  parameter int unsigned KelvinStep = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic signed [36:0] Day = 37'(SecondsPerDay);
  localparam logic signed [36:0] U32Max = 37'sh0FFFFFFFF;
  localparam logic [19:0] StepMax = 20'hFFFFF;

  logic [15:0] low_q, high_q;
  logic [16:0] sunrise_q, sunset_q, dur_q;
  logic signed [17:0] offset_q;

  logic [1:0]  force_q, force_d;
  logic        valid_q, valid_d;
  logic signed [36:0] day_q, day_d, dawn_q, dawn_d, rise_q, rise_d;
  logic signed [36:0] set_q, set_d, dusk_q, dusk_d, cur_day_q, cur_day_d;
  logic [19:0] step_q, step_d;
  logic [15:0] last_q, last_d;
  logic [31:0] now_q, now_d;
  logic        neg_q, neg_d;
  logic        falling_q, falling_d;
  logic [32:0] mag_q, mag_d;
  logic [16:0] dq_q, dq_d;
  logic [16:0] dr_q, dr_d;
  logic [15:0] tmp_q, tmp_d;
  logic [31:0] dl_q, dl_d;
  state_e      st_q, st_d;
  out_item_t   res_q, res_d;
  logic        ov_q, ov_d;

  div_req_t req;
  div_rsp_t rsp;

  dncts_div u_div (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  assign in_ready_o  = (st_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  function automatic logic [31:0] sat32(logic signed [36:0] v);
    if (v[36]) return 32'd0;
    if (v > U32Max) return 32'hFFFFFFFF;
    return v[31:0];
  endfunction

  // Config registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= 16'd4000; high_q <= 16'd6500;
      sunrise_q <= '0; sunset_q <= '0; dur_q <= '0; offset_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLowTemp:   low_q <= cfg_data_i[15:0];
        CfgHighTemp:  high_q <= cfg_data_i[15:0];
        CfgSunrise:   sunrise_q <= cfg_data_i[16:0];
        CfgSunset:    sunset_q <= cfg_data_i[16:0];
        CfgDuration:  dur_q <= cfg_data_i[16:0];
        CfgDayOffset: offset_q <= signed'(cfg_data_i[17:0]);
        default: ;
      endcase
    end
  end

  logic signed [36:0] x_s, nows, t0, t1, day_c, ramp_t;
  logic [32:0] mag_c;
  logic [52:0] prod_c;
  logic [26:0] qm_c;
  logic [16:0] dr_c;
  logic [16:0] diff_u, kmag;
  logic signed [16:0] diff_s, kdiff;
  logic [16:0] num_c;

  always_comb begin
    nows   = signed'({5'd0, now_q});
    x_s    = nows - 37'(offset_q);
    mag_c  = 33'(x_s[36] ? -x_s : x_s);
    // Remainder by 86400: the low 7 bits pass through, the rest is taken mod 675.
    prod_c = 53'(mag_q[32:7]) * 53'(DayRecip);
    qm_c   = 27'(dq_q) * 27'(DayFactor);
    dr_c   = {10'(27'(mag_q[32:7]) - qm_c), mag_q[6:0]};
    day_c  = neg_q ? nows + 37'(dr_q) : nows - 37'(dr_q);
    diff_s = signed'({1'b0, high_q}) - signed'({1'b0, low_q});
    diff_u = 17'(diff_s);
    t0     = falling_q ? set_q : dawn_q;
    t1     = falling_q ? dusk_q : rise_q;
    kdiff  = falling_q ? -diff_s : diff_s;
    kmag   = 17'(kdiff[16] ? -kdiff : kdiff);
    num_c  = 17'(nows - t0);
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:     if (in_valid_i && in_ready_o) st_d = StDayAbs;
      StDayAbs:   st_d = StDayMul;
      StDayMul:   st_d = StDayRem;
      StDayRem:   st_d = StDaySel;
      StDaySel: begin
        priority if (force_q != ForceOff) st_d = StOut;
        else if (!valid_q || day_c != day_q) st_d = StStops;
        else st_d = StMul;
      end
      StStops:    st_d = StStepDiv;
      StStepDiv:  st_d = (diff_s <= 0) ? StMul : StStepWait;
      StStepWait: if (rsp.done) st_d = StMul;
      StMul: begin
        // Ramps go on to the divider; every other segment is final here.
        priority if (nows < dawn_q) st_d = StOut;
        else if (nows < rise_q) st_d = StRampDiv;
        else if (nows < set_q) st_d = StOut;
        else if (nows < dusk_q) st_d = StRampDiv;
        else st_d = StOut;
      end
      StRampDiv:  st_d = StRampWait;
      StRampWait: if (rsp.done) st_d = StOut;
      StOut:      if (!ov_q) st_d = StIdle;
      default:    st_d = StIdle;
    endcase
  end

  // Datapath and divider requests.
  always_comb begin
    force_d = force_q; valid_d = valid_q;
    day_d = day_q; dawn_d = dawn_q; rise_d = rise_q; set_d = set_q; dusk_d = dusk_q;
    cur_day_d = cur_day_q; step_d = step_q; last_d = last_q; now_d = now_q;
    neg_d = neg_q; falling_d = falling_q; mag_d = mag_q; dq_d = dq_q; dr_d = dr_q;
    tmp_d = tmp_q; dl_d = dl_q; res_d = res_q; ov_d = ov_q;
    req = '0;
    ramp_t = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      StIdle: if (in_valid_i && in_ready_o) begin
        now_d = in_data_i.now;
        if (in_data_i.operation) begin
          force_d = (force_q == ForceOff) ? ForceHigh :
                    (force_q == ForceHigh) ? ForceLow : ForceOff;
          valid_d = 1'b0;
        end
      end
      StDayAbs: begin
        neg_d = x_s[36];
        mag_d = mag_c;
      end
      StDayMul: dq_d = prod_c[52:36];
      StDayRem: dr_d = dr_c;
      StDaySel: begin
        cur_day_d = day_c;
        if (force_q != ForceOff) begin
          tmp_d = (force_q == ForceHigh) ? high_q : low_q;
          dl_d = sat32(day_c + Day);
        end
      end
      StStops: begin
        valid_d = 1'b1;
        day_d  = cur_day_q;
        rise_d = cur_day_q + 37'(sunrise_q);
        dawn_d = cur_day_q + 37'(sunrise_q) - 37'(dur_q);
        set_d  = cur_day_q + 37'(sunset_q);
        dusk_d = cur_day_q + 37'(sunset_q) + 37'(dur_q);
      end
      StStepDiv: begin
        if (diff_s <= 0) begin
          step_d = 20'd1;
        end else begin
          req.start = 1'b1;
          req.dividend = 40'(dur_q) * 40'(KelvinStep);
          req.divisor = 40'(diff_u);
        end
      end
      StStepWait: if (rsp.done) begin
        step_d = (rsp.quotient == '0) ? 20'd1 :
                 (rsp.quotient > 40'(StepMax)) ? StepMax : rsp.quotient[19:0];
      end
      StMul: begin
        priority if (nows < dawn_q) begin
          tmp_d = low_q; dl_d = sat32(dawn_q);
        end else if (nows < rise_q) begin
          falling_d = 1'b0;
        end else if (nows < set_q) begin
          tmp_d = high_q; dl_d = sat32(set_q);
        end else if (nows < dusk_q) begin
          falling_d = 1'b1;
        end else begin
          tmp_d = low_q; dl_d = sat32(day_q + Day);
        end
      end
      StRampDiv: begin
        neg_d = kdiff[16];
        req.start = 1'b1;
        req.dividend = 40'(37'(num_c) * 37'(kmag));
        req.divisor = 40'(37'(t1 - t0));
      end
      StRampWait: if (rsp.done) begin
        ramp_t = (falling_q ? signed'({21'd0, high_q}) : signed'({21'd0, low_q})) +
                 (neg_q ? -signed'(rsp.quotient[36:0]) : signed'(rsp.quotient[36:0]));
        tmp_d = ramp_t[15:0];
        dl_d = sat32(nows + 37'(step_q));
      end
      StOut: if (!ov_q) begin
        res_d.temperature = tmp_q;
        res_d.deadline = dl_q;
        res_d.force_mode = force_q;
        res_d.temp_changed = (tmp_q != last_q);
        last_d = tmp_q;
        ov_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; force_q <= ForceOff; valid_q <= 1'b0; ov_q <= 1'b0;
      day_q <= '0; dawn_q <= '0; rise_q <= '0; set_q <= '0; dusk_q <= '0;
      step_q <= 20'd1; last_q <= '0;
    end else begin
      st_q <= st_d; force_q <= force_d; valid_q <= valid_d; ov_q <= ov_d;
      day_q <= day_d; dawn_q <= dawn_d; rise_q <= rise_d; set_q <= set_d;
      dusk_q <= dusk_d; step_q <= step_d; last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d; neg_q <= neg_d; falling_q <= falling_d; mag_q <= mag_d;
    dq_q <= dq_d; dr_q <= dr_d; tmp_q <= tmp_d; dl_q <= dl_d;
    cur_day_q <= cur_day_d; res_q <= res_d;
  end

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (st_q != StIdle) |-> !in_ready_o;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");

  property p_force_legal;
    @(posedge clk_i) disable iff (!rst_ni) force_q != 2'd3;
  endproperty
  a_force_legal: assert property (p_force_legal) else $error("bad force mode");

  property p_step_nonzero;
    @(posedge clk_i) disable iff (!rst_ni) step_q != '0;
  endproperty
  a_step_nonzero: assert property (p_step_nonzero) else $error("zero step time");

  property p_out_from_st;
    @(posedge clk_i) disable iff (!rst_ni) $rose(ov_q) |-> $past(st_q) == StOut;
  endproperty
  a_out_from_st: assert property (p_out_from_st) else $error("result without sequencer");

endmodule

FILE: tb/sv/day_night_color_temp_scheduler_unit_test.sv
// Testbench for the day/night color temperature scheduler: predicts each result and checks it.
// Depends on dncts_pkg and the day_night_color_temp_scheduler_unit RTL.
module day_night_color_temp_scheduler_unit_test;
  import dncts_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam longint DaySec = 86400;
  localparam longint StepMax = 64'hFFFFF;
  localparam longint KelvinStep = 10;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_idx_e   cfg_index;
  logic [31:0] cfg_data;

  day_night_color_temp_scheduler_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Shadow copy of the registers and of the scheduler state.
  longint  low_k, high_k, sunrise_s, sunset_s, ramp_s, offset_s;
  force_e  mode;
  bit      day_known;
  longint  day_start, dawn_t, rise_t, set_t, dusk_t, dawn_step, dusk_step;
  logic [15:0] last_temp;

  out_item_t pending_results[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned hold_cycles;
  int unsigned stall_pct;
  int unsigned burst_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint step_time(longint span);
    longint diff;
    longint s;
    diff = high_k - low_k;
    if (diff <= 0) return 1;
    s = span * KelvinStep / diff;
    if (s < 1) s = 1;
    if (s > StepMax) s = StepMax;
    return s;
  endfunction

  function automatic longint ramp_temp(longint t, longint t0, longint t1, longint k0,
                                       longint k1);
    longint den;
    longint num;
    den = t1 - t0;
    num = t - t0;
    if (den <= 0) return k1;
    if (num < 0) num = 0;
    if (num > den) num = den;
    return k0 + (k1 - k0) * num / den;
  endfunction

  function automatic out_item_t schedule_eval(in_item_t item);
    out_item_t res;
    longint t;
    longint day;
    longint temp;
    longint dl;
    t = longint'(item.now);
    if (item.operation) begin
      case (mode)
        ForceOff:  mode = ForceHigh;
        ForceHigh: mode = ForceLow;
        default:   mode = ForceOff;
      endcase
      day_known = 1'b0;
    end
    day = t - ((t - offset_s) % DaySec);
    if (mode != ForceOff) begin
      temp = (mode == ForceHigh) ? high_k : low_k;
      dl = day + DaySec;
    end else begin
      if (!day_known || day != day_start) begin
        day_known = 1'b1;
        day_start = day;
        dawn_t = day + sunrise_s - ramp_s;
        rise_t = day + sunrise_s;
        set_t = day + sunset_s;
        dusk_t = day + sunset_s + ramp_s;
        dawn_step = step_time(rise_t - dawn_t);
        dusk_step = step_time(dusk_t - set_t);
      end
      if (t < dawn_t) begin
        temp = low_k;
        dl = dawn_t;
      end else if (t < rise_t) begin
        temp = ramp_temp(t, dawn_t, rise_t, low_k, high_k);
        dl = t + dawn_step;
      end else if (t < set_t) begin
        temp = high_k;
        dl = set_t;
      end else if (t < dusk_t) begin
        temp = ramp_temp(t, set_t, dusk_t, high_k, low_k);
        dl = t + dusk_step;
      end else begin
        temp = low_k;
        dl = day + DaySec;
      end
    end
    if (dl < 0) dl = 0;
    if (dl > 64'hFFFFFFFF) dl = 64'hFFFFFFFF;
    res.temperature = temp[15:0];
    res.deadline = dl[31:0];
    res.force_mode = mode;
    res.temp_changed = (temp[15:0] != last_temp);
    last_temp = temp[15:0];
    return res;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.temperature !== exp_res.temperature) begin
          $display("%0t: temperature expected %0d actual %0d", $time,
                   exp_res.temperature, out_data.temperature);
          errors++;
        end
        if (out_data.deadline !== exp_res.deadline) begin
          $display("%0t: deadline expected %0d actual %0d", $time,
                   exp_res.deadline, out_data.deadline);
          errors++;
        end
        if (out_data.force_mode !== exp_res.force_mode) begin
          $display("%0t: force_mode expected %0d actual %0d", $time,
                   exp_res.force_mode, out_data.force_mode);
          errors++;
        end
        if (out_data.temp_changed !== exp_res.temp_changed) begin
          $display("%0t: temp_changed expected %0d actual %0d", $time,
                   exp_res.temp_changed, out_data.temp_changed);
          errors++;
        end
      end
    end
  end

  // Receiver: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgLowTemp:   low_k = longint'(data[15:0]);
      CfgHighTemp:  high_k = longint'(data[15:0]);
      CfgSunrise:   sunrise_s = longint'(data[16:0]);
      CfgSunset:    sunset_s = longint'(data[16:0]);
      CfgDuration:  ramp_s = longint'(data[16:0]);
      CfgDayOffset: offset_s = longint'($signed(data[17:0]));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Upper bits beyond each register's width are random; they must be dropped.
  task automatic set_schedule(int lo, int hi, int rise, int set, int dur, int off);
    cfg_write(CfgLowTemp, {16'($urandom_range(0, 65535)), 16'(lo)});
    cfg_write(CfgHighTemp, {16'($urandom_range(0, 65535)), 16'(hi)});
    cfg_write(CfgSunrise, {15'($urandom), 17'(rise)});
    cfg_write(CfgSunset, {15'($urandom), 17'(set)});
    cfg_write(CfgDuration, {15'($urandom), 17'(dur)});
    cfg_write(CfgDayOffset, {14'($urandom), 18'(off)});
    cfg_write(cfg_idx_e'(3'd6), $urandom);
    cfg_write(cfg_idx_e'(3'd7), $urandom);
  endtask

  task automatic send_item(bit op, logic [31:0] t);
    int unsigned gap;
    in_item_t item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item.operation = op;
    item.now = t;
    in_data = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(schedule_eval(item));
    @(negedge clk);
  endtask

  // Idle the sender until every result is back, then let the block settle.
  task automatic drain;
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic test_directed;
    send_item(1'b0, 32'd0);
    send_item(1'b0, 32'hFFFFFFFF);
    send_item(1'b0, 32'd0);
    send_item(1'b1, 32'd1000);
    send_item(1'b1, 32'd2000);
    send_item(1'b1, 32'd3000);
    send_item(1'b0, 32'h80000000);
    drain();
    set_schedule(3000, 6500, 21600, 64800, 3600, -3600);
    for (int i = 0; i < 12; i++) send_item(1'b0, 32'(86400 * 3 + 3600 + i * 7200));
    send_item(1'b1, 32'hFFFFFFF0);
    send_item(1'b1, 32'hFFFFFFF0);
    send_item(1'b1, 32'hFFFFFFF0);
    send_item(1'b0, 32'd5);
    drain();
  endtask

  task automatic test_backpressure;
    hold_cycles = 600;
    for (int i = 0; i < 10; i++) send_item(1'b0, 32'(86400 * 10 + i * 5000));
    drain();
  endtask

  task automatic random_setting(int kind);
    case (kind)
      0: set_schedule(1000, 40000, 0, 86399, 86400, 86400);
      1: set_schedule(40000, 1000, 86399, 0, 0, -86400);
      2: set_schedule(5000, 5000, 43200, 43200, 86400, 0);
      3: set_schedule(65535, 0, 1, 2, 86400, -1);
      default: set_schedule($urandom_range(1000, 40000), $urandom_range(1000, 40000),
                            $urandom_range(0, 86399), $urandom_range(0, 86399),
                            ($urandom_range(0, 1) ? $urandom_range(0, 7200)
                                                  : $urandom_range(0, 86400)),
                            $urandom_range(0, 172800) - 86400);
    endcase
  endtask

  task automatic test_random;
    longint base;
    longint t;
    for (int phase = 0; phase < 12; phase++) begin
      random_setting(phase);
      stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
      for (int i = 0; i < 104; i++) begin
        if (i % 20 == 0) begin
          base = longint'($urandom_range(0, 49709)) * DaySec;
          t = base;
        end
        case ($urandom_range(0, 9))
          0: send_item(1'b0, $urandom);
          1: send_item(1'b1, 32'(t));
          default: begin
            t = t + $urandom_range(0, 9000);
            if (t > 64'hFFFFFFFF) t = 64'hFFFFFFFF;
            send_item(1'b0, 32'(t));
          end
        endcase
      end
      drain();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CfgLowTemp;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    stall_pct = 20;
    burst_left = 0;
    low_k = 4000;
    high_k = 6500;
    sunrise_s = 0;
    sunset_s = 0;
    ramp_s = 0;
    offset_s = 0;
    mode = ForceOff;
    day_known = 1'b0;
    day_start = 0;
    dawn_t = 0;
    rise_t = 0;
    set_t = 0;
    dusk_t = 0;
    dawn_step = 1;
    dusk_step = 1;
    last_temp = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/dncts_pkg.sv
hdl/dncts_div.sv
hdl/day_night_color_temp_scheduler_unit.sv
tb/sv/day_night_color_temp_scheduler_unit_test.sv
